>>> rtl/core/aqpg_pkg.sv
// Shared types, constants and helpers for the adaptive quality governor.
package aqpg_pkg;

    localparam int unsigned IntegralLimitDefault = 25600;

    localparam logic [2:0] CfgBudgetMax = 3'd0;
    localparam logic [2:0] CfgBudgetMin = 3'd1;
    localparam logic [2:0] CfgScaleMin  = 3'd2;
    localparam logic [2:0] CfgScaleMax  = 3'd3;
    localparam logic [2:0] CfgModeFlags = 3'd4;
    localparam logic [2:0] CfgGainP     = 3'd5;
    localparam logic [2:0] CfgGainI     = 3'd6;
    localparam logic [2:0] CfgGainD     = 3'd7;

    typedef struct packed {
        logic [15:0] headroom;
        logic [15:0] free_mem_mb;
        logic [15:0] quality_db;
        logic [7:0]  goal_fps;
        logic [15:0] frame_ms;
    } aqpg_in_t;

    typedef struct packed {
        logic [19:0] prim_budget;
        logic [15:0] res_scale;
        logic [1:0]  harmonic_order;
        logic [2:0]  iters_per_frame;
        logic        half_precision;
        logic [9:0]  densify;
        logic [15:0] depth_weight;
        logic        back_path;
        logic [1:0]  tier;
    } aqpg_out_t;

    // Classified request handed from front to back.
    typedef struct packed {
        logic [19:0] budget;
        logic [16:0] scale;
        logic [1:0]  order;
        logic [2:0]  iters;
        logic        half;
        logic [9:0]  dens;
        logic [15:0] depth;
        logic        path;
        logic [1:0]  tier;
        logic [17:0] err;
    } aqpg_job_t;

    // Target frame time round(256000/fps) in Q10.8; fps 0 gives 16.67 ms.
    function automatic logic [17:0] target_time(input logic [5:0] fps);
        logic [17:0] t;
        t = 18'd4268;
        if (fps != 6'd0)
        begin
            t = 18'((32'd256000 + 32'(fps >> 1)) / 32'(fps));
        end
        return t;
    endfunction

endpackage

>>> rtl/core/aqpg_front.sv
// Front part: tier, memory and quality rules plus the frame-time error.
module aqpg_front (
    input  logic               valid,
    input  aqpg_pkg::aqpg_in_t in_data,
    input  logic [19:0]        budget_max,
    input  logic [19:0]        budget_min,
    input  logic [15:0]        scale_min,
    input  logic [15:0]        scale_max,
    input  logic [1:0]         mode_flags,
    input  logic               q_full,
    output logic               stall,
    output logic               push,
    output aqpg_pkg::aqpg_job_t job
);
    import aqpg_pkg::*;

    // Table of round(256000/fps) for fps 1..63, entry 0 the zero-rate default.
    logic [17:0] tgt_rom [64];
    always_comb
    begin
        for (int k = 0; k < 64; k++)
        begin
            tgt_rom[k] = target_time(6'(k));
        end
    end

    logic [19:0] b70, b40;
    logic [17:0] m3;
    logic [35:0] m3q;
    logic [27:0] mcap;

    // budget_max*7/10 and *4/10, free_mem_mb*12288/5, by reciprocal multiply.
    logic [47:0] d7, d4;
    always_comb
    begin
        d7 = 48'(budget_max) * 48'd93952411;     // 7*ceil(2^27/10)
        b70 = 20'(d7 >> 27);
        d4 = 48'(budget_max) * 48'd53687092;     // 4*ceil(2^27/10)
        b40 = 20'(d4 >> 27);
        // 12288/5 = 2457 + 3/5
        m3 = 18'(in_data.free_mem_mb) * 18'd3;
        m3q = 36'(m3) * 36'd209716;              // ceil(2^20/5)
        mcap = 28'(in_data.free_mem_mb) * 28'd2457 + 28'(m3q >> 20);
    end

    logic [1:0]  tr;
    logic [19:0] bud;
    logic [16:0] sc;
    logic [1:0]  ord;
    logic [2:0]  it;
    logic        hf, pth;
    logic [9:0]  dn;
    logic [15:0] dw;
    logic [5:0]  cap, fps;
    logic [18:0] e19;
    logic [17:0] err;

    assign stall = q_full;
    assign push  = valid && !q_full;

    always_comb
    begin
        if (in_data.headroom > 16'd32768)      tr = 2'd0;
        else if (in_data.headroom > 16'd19660) tr = 2'd1;
        else if (in_data.headroom > 16'd9830)  tr = 2'd2;
        else                                   tr = 2'd3;

        bud = budget_max;
        sc  = {1'b0, scale_max};
        ord = 2'd3;
        it  = 3'd4;
        hf  = mode_flags[0];
        dn  = 10'd256;
        dw  = 16'd6554;
        pth = mode_flags[1];
        case (tr)
            2'd1:
            begin
                it = 3'd3;
                dn = 10'd205;
            end
            2'd2:
            begin
                if (sc > 17'd24576) sc = 17'd24576;
                it  = 3'd2;
                ord = 2'd2;
                dn  = 10'd128;
                pth = 1'b0;
                bud = b70;
            end
            2'd3:
            begin
                sc  = {1'b0, scale_min};
                it  = 3'd1;
                ord = 2'd1;
                dn  = 10'd0;
                hf  = 1'b1;
                pth = 1'b0;
                bud = (b40 < budget_min) ? budget_min : b40;
            end
            default:
            begin
            end
        endcase

        if (in_data.free_mem_mb != 16'd0)
        begin
            if (mcap < 28'(bud)) bud = 20'(mcap);
            if (in_data.free_mem_mb < 16'd100 && sc > 17'd24576) sc = 17'd24576;
            if (in_data.free_mem_mb < 16'd50)
            begin
                if (sc > 17'd16384) sc = 17'd16384;
                hf = 1'b1;
            end
        end

        if (in_data.quality_db > 16'd0 && in_data.quality_db < 16'd5120)
        begin
            if (it < 3'd6) it = 3'd6;
            dn = 10'((11'(dn) * 11'd3) >> 1);
            if (dn > 10'd512) dn = 10'd512;
            dw = 16'd13107;
        end

        case (tr)
            2'd0:    cap = 6'd60;
            2'd1:    cap = 6'd50;
            2'd2:    cap = 6'd30;
            default: cap = 6'd24;
        endcase
        fps = (in_data.goal_fps < 8'(cap)) ? 6'(in_data.goal_fps) : cap;
        e19 = 19'(tgt_rom[fps]) - 19'(in_data.frame_ms);
        // Saturate a long target time to the largest positive error.
        if (!e19[18] && e19[17]) err = 18'h1FFFF;
        else                     err = e19[17:0];

        job.budget = bud;
        job.scale  = sc;
        job.order  = ord;
        job.iters  = it;
        job.half   = hf;
        job.dens   = dn;
        job.depth  = dw;
        job.path   = pth;
        job.tier   = tr;
        job.err    = err;
    end

endmodule

>>> rtl/core/aqpg_queue.sv
// Two-entry request queue between front and back.
module aqpg_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  aqpg_pkg::aqpg_job_t push_data,
    input  logic                pop,
    output logic                full,
    output logic                not_empty,
    output aqpg_pkg::aqpg_job_t head
);
    import aqpg_pkg::*;

    aqpg_job_t mem_reg [2];
    logic      wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

>>> rtl/core/aqpg_back.sv
// Back part: PID update on one shared multiplier, pressure scaling and clamps.
module aqpg_back #(
    parameter int unsigned INTEGRAL_LIMIT = aqpg_pkg::IntegralLimitDefault
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  aqpg_pkg::aqpg_job_t q_head,
    output logic                pop,
    input  logic [19:0]         budget_max,
    input  logic [19:0]         budget_min,
    input  logic [15:0]         scale_min,
    input  logic [15:0]         scale_max,
    input  logic [15:0]         gain_p,
    input  logic [15:0]         gain_i,
    input  logic [15:0]         gain_d,
    input  logic                stall,
    output logic                valid,
    output aqpg_pkg::aqpg_out_t out_data
);
    import aqpg_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_P, S_I, S_D, S_DIV, S_PRS, S_BUD, S_SCL, S_FIN, S_OUT
    } state_t;

    localparam logic signed [24:0] LimPos = 25'(INTEGRAL_LIMIT);
    localparam logic signed [24:0] LimNeg = -25'(INTEGRAL_LIMIT);

    state_t             state_reg;
    aqpg_job_t          job_reg;
    logic signed [23:0] sum_reg;
    logic signed [17:0] last_reg;
    logic signed [18:0] der_reg;
    logic signed [40:0] acc_reg;
    logic signed [40:0] prod_reg;
    logic [40:0]        mag_reg;
    logic [36:0]        q_reg;
    logic [16:0]        p_reg;
    logic [19:0]        bud_reg;
    logic [16:0]        sc_reg;
    logic               valid_reg;
    aqpg_out_t          out_reg;

    // Shared signed multiplier operands.
    logic signed [24:0] ma;
    logic signed [16:0] mb;
    logic signed [41:0] mp;
    logic signed [24:0] sum_n;
    logic [37:0]        qm;
    logic [37:0]        bm;
    logic [19:0]        bclamp;
    logic [16:0]        sclamp;

    always_comb
    begin
        sum_n = 25'(sum_reg) + 25'(signed'(job_reg.err));
        if (sum_n > LimPos) sum_n = LimPos;
        if (sum_n < LimNeg) sum_n = LimNeg;

        ma = 25'(signed'(job_reg.err));
        mb = signed'({1'b0, gain_p});
        case (state_reg)
            S_I:
            begin
                ma = 25'(sum_reg);
                mb = signed'({1'b0, gain_i});
            end
            S_D:
            begin
                ma = 25'(der_reg);
                mb = signed'({1'b0, gain_d});
            end
            S_BUD:
            begin
                ma = signed'({5'd0, bud_reg});
                mb = signed'(p_reg);
            end
            S_SCL:
            begin
                ma = signed'({8'd0, sc_reg});
                mb = signed'(p_reg);
            end
            default:
            begin
            end
        endcase
        mp = 42'(ma) * 42'(mb);
        bm = 38'(mp);

        // Divide magnitude by 20: drop two bits, then multiply by ceil(2^20/5).
        // Only magnitudes below 20*45875 need the quotient; larger ones floor the pressure.
        qm = 38'(mag_reg[19:2]) * 38'd209716;
        bclamp = bud_reg;
        if (bud_reg < budget_min)      bclamp = budget_min;
        else if (bud_reg > budget_max) bclamp = budget_max;
        sclamp = sc_reg;
        if (sc_reg < 17'(scale_min))      sclamp = 17'(scale_min);
        else if (sc_reg > 17'(scale_max)) sclamp = 17'(scale_max);
    end

    assign pop      = (state_reg == S_IDLE) && q_valid;
    assign valid    = valid_reg;
    assign out_data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sum_reg   <= '0;
            last_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        job_reg   <= q_head;
                        state_reg <= S_P;
                    end
                end
                S_P:
                begin
                    prod_reg  <= 41'(mp);
                    der_reg   <= 19'(signed'(job_reg.err)) - 19'(last_reg);
                    last_reg  <= signed'(job_reg.err);
                    sum_reg   <= 24'(sum_n);
                    state_reg <= S_I;
                end
                S_I:
                begin
                    acc_reg   <= prod_reg;
                    prod_reg  <= 41'(mp);
                    state_reg <= S_D;
                end
                S_D:
                begin
                    acc_reg   <= acc_reg + prod_reg + 41'(mp);
                    bud_reg   <= job_reg.budget;
                    sc_reg    <= job_reg.scale;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (acc_reg < -41'sd65536)
                    begin
                        mag_reg   <= 41'(-acc_reg);
                        state_reg <= S_PRS;
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_PRS:
                begin
                    if (mag_reg >= 41'd917500) q_reg <= 37'd45875;
                    else q_reg <= 37'(qm >> 20);
                    state_reg <= S_BUD;
                    p_reg     <= 17'd0;
                end
                S_BUD:
                begin
                    if (p_reg == 17'd0)
                    begin
                        // Pressure first, then scale by it on the next pass.
                        if (q_reg >= 37'd45875) p_reg <= 17'd19661;
                        else p_reg <= 17'(37'd65536 - q_reg);
                    end
                    else
                    begin
                        bud_reg   <= 20'(bm >> 16);
                        state_reg <= S_SCL;
                    end
                end
                S_SCL:
                begin
                    sc_reg <= 17'(bm >> 16);
                    if (p_reg < 17'd39322 && job_reg.iters > 3'd1)
                        job_reg.iters <= job_reg.iters - 3'd1;
                    if (p_reg < 17'd26215 && job_reg.order > 2'd1)
                        job_reg.order <= job_reg.order - 2'd1;
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (!valid_reg || !stall)
                    begin
                        out_reg.prim_budget     <= bclamp;
                        out_reg.res_scale       <= sclamp[15:0];
                        out_reg.harmonic_order  <= job_reg.order;
                        out_reg.iters_per_frame <= job_reg.iters;
                        out_reg.half_precision  <= job_reg.half;
                        out_reg.densify         <= job_reg.dens;
                        out_reg.depth_weight    <= job_reg.depth;
                        out_reg.back_path       <= job_reg.path;
                        out_reg.tier            <= job_reg.tier;
                        valid_reg               <= 1'b1;
                        state_reg               <= S_IDLE;
                    end
                end
                S_OUT:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (valid_reg && !stall && !(state_reg == S_FIN))
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/core/adaptive_quality_pid_governor_unit.sv
// Top level of the adaptive quality PID governor.
//   channel | valid      | stall      | payload
//   in      | in_valid   | in_stall   | in_data  (aqpg_in_t)
//   out     | out_valid  | out_stall  | out_data (aqpg_out_t)
//   cfg     | cfg_we     | -          | cfg_index, cfg_data
// The back part runs an item from pop through P, I, D and divide states;
// frame-time pressure adds budget and scale steps on the shared multiplier.
// The front part classifies in the accepting cycle into a two-entry queue.
// Reset clears registers to defaults and the PID state to zero.
// A stalled result holds in the output register; the queue keeps accepting
// until both entries are full.
module adaptive_quality_pid_governor_unit #(
    parameter int unsigned INTEGRAL_LIMIT = aqpg_pkg::IntegralLimitDefault
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  aqpg_pkg::aqpg_in_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output aqpg_pkg::aqpg_out_t out_data,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [19:0]        cfg_data
);
    import aqpg_pkg::*;

    logic [19:0] budget_max_reg, budget_min_reg;
    logic [15:0] scale_min_reg, scale_max_reg, gain_p_reg, gain_i_reg, gain_d_reg;
    logic [1:0]  mode_flags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_max_reg <= 20'd100000;
            budget_min_reg <= 20'd10000;
            scale_min_reg  <= 16'd16384;
            scale_max_reg  <= 16'd32768;
            mode_flags_reg <= 2'd0;
            gain_p_reg     <= 16'd128;
            gain_i_reg     <= 16'd3;
            gain_d_reg     <= 16'd13;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CfgBudgetMax: budget_max_reg <= cfg_data;
                CfgBudgetMin: budget_min_reg <= cfg_data;
                CfgScaleMin:  scale_min_reg  <= cfg_data[15:0];
                CfgScaleMax:  scale_max_reg  <= cfg_data[15:0];
                CfgModeFlags: mode_flags_reg <= cfg_data[1:0];
                CfgGainP:     gain_p_reg     <= cfg_data[15:0];
                CfgGainI:     gain_i_reg     <= cfg_data[15:0];
                CfgGainD:     gain_d_reg     <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    logic      q_full, q_ne, push, pop;
    aqpg_job_t job, head;

    aqpg_front u_front (
        .valid(in_valid), .in_data(in_data),
        .budget_max(budget_max_reg), .budget_min(budget_min_reg),
        .scale_min(scale_min_reg), .scale_max(scale_max_reg),
        .mode_flags(mode_flags_reg), .q_full(q_full), .stall(in_stall),
        .push(push), .job(job)
    );

    aqpg_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(job), .pop(pop),
        .full(q_full), .not_empty(q_ne), .head(head)
    );

    aqpg_back #(.INTEGRAL_LIMIT(INTEGRAL_LIMIT)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_ne), .q_head(head), .pop(pop),
        .budget_max(budget_max_reg), .budget_min(budget_min_reg),
        .scale_min(scale_min_reg), .scale_max(scale_max_reg),
        .gain_p(gain_p_reg), .gain_i(gain_i_reg), .gain_d(gain_d_reg),
        .stall(out_stall), .valid(out_valid), .out_data(out_data)
    );

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !push) else $error("push into full queue");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_ne) else $error("pop from empty queue");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");
`endif

endmodule

>>> tb/adaptive_quality_pid_governor_unit_tb.sv
// Self-checking testbench for the adaptive quality PID governor.
module adaptive_quality_pid_governor_unit_tb;
    import aqpg_pkg::*;

    localparam int IntLimit = 25600;
    localparam int unsigned CycleLimit = 400000;

    // Holds governor settings and PID state; predicts settings per frame report.
    class governor_scoreboard;
        bit [19:0] bmax, bmin;
        bit [15:0] smin, smax;
        bit [1:0] flags;
        bit [15:0] kp, ki, kd;
        longint acc, prev_err;
        aqpg_out_t pending[$];
        int errors;

        function void reset_state();
            bmax = 100000; bmin = 10000; smin = 16384; smax = 32768;
            flags = 0; kp = 128; ki = 3; kd = 13;
            acc = 0; prev_err = 0; errors = 0;
            pending.delete();
        endfunction

        function void write_reg(logic [2:0] idx, logic [19:0] v);
            case (idx)
                CfgBudgetMax: bmax = v;
                CfgBudgetMin: bmin = v;
                CfgScaleMin: smin = v[15:0];
                CfgScaleMax: smax = v[15:0];
                CfgModeFlags: flags = v[1:0];
                CfgGainP: kp = v[15:0];
                CfgGainI: ki = v[15:0];
                CfgGainD: kd = v[15:0];
                default: ;
            endcase
        endfunction

        function void note_request(aqpg_in_t r);
            longint unsigned budget, scale, mcap, mag, q;
            int unsigned order, iters, half, dens, depth, path, tier, cap, fps, target;
            longint e, s, d, pid, p;
            aqpg_out_t o;
            budget = bmax; scale = smax; order = 3; iters = 4; half = flags[0];
            dens = 256; depth = 6554; path = flags[1];
            if (r.headroom > 32768) tier = 0;
            else if (r.headroom > 19660) tier = 1;
            else if (r.headroom > 9830) tier = 2;
            else tier = 3;
            if (tier == 1)
            begin
                iters = 3; dens = 205;
            end
            else if (tier == 2)
            begin
                if (scale > 24576) scale = 24576;
                iters = 2; order = 2; dens = 128; path = 0;
                budget = (longint'(bmax) * 7) / 10;
            end
            else if (tier == 3)
            begin
                scale = smin; iters = 1; order = 1; dens = 0; half = 1; path = 0;
                budget = (longint'(bmax) * 4) / 10;
                if (budget < bmin) budget = bmin;
            end
            if (r.free_mem_mb != 0)
            begin
                mcap = (longint'(r.free_mem_mb) * 12288) / 5;
                if (mcap < budget) budget = mcap;
                if (r.free_mem_mb < 100 && scale > 24576) scale = 24576;
                if (r.free_mem_mb < 50)
                begin
                    if (scale > 16384) scale = 16384;
                    half = 1;
                end
            end
            if (r.quality_db > 0 && r.quality_db < 5120)
            begin
                if (iters < 6) iters = 6;
                dens = dens * 3 / 2;
                if (dens > 512) dens = 512;
                depth = 13107;
            end
            cap = (tier == 0) ? 60 : (tier == 1) ? 50 : (tier == 2) ? 30 : 24;
            fps = (r.goal_fps < cap) ? r.goal_fps : cap;
            target = (fps > 0) ? (256000 + fps / 2) / fps : 4268;
            e = longint'(target) - longint'(r.frame_ms);
            if (e > 131071) e = 131071;
            if (e < -131072) e = -131072;
            s = acc + e;
            if (s > IntLimit) s = IntLimit;
            if (s < -IntLimit) s = -IntLimit;
            acc = s;
            d = e - prev_err;
            prev_err = e;
            pid = longint'(kp) * e + longint'(ki) * s + longint'(kd) * d;
            if (pid < -65536)
            begin
                mag = -pid;
                q = mag / 20;
                p = (q > 65536) ? 0 : 65536 - longint'(q);
                if (p < 19661) p = 19661;
                budget = (budget * p) >> 16;
                scale = (scale * p) >> 16;
                if (p < 39322 && iters > 1) iters--;
                if (p < 26215 && order > 1) order--;
            end
            if (budget < bmin) budget = bmin;
            else if (budget > bmax) budget = bmax;
            if (scale < smin) scale = smin;
            else if (scale > smax) scale = smax;
            o.prim_budget = budget[19:0];
            o.res_scale = scale[15:0];
            o.harmonic_order = order[1:0];
            o.iters_per_frame = iters[2:0];
            o.half_precision = half[0];
            o.densify = dens[9:0];
            o.depth_weight = depth[15:0];
            o.back_path = path[0];
            o.tier = tier[1:0];
            pending.push_back(o);
        endfunction

        function void check_result(aqpg_out_t got);
            aqpg_out_t exp_o;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp_o = pending.pop_front();
            if (got.prim_budget != exp_o.prim_budget)
                report("prim_budget", exp_o.prim_budget, got.prim_budget);
            if (got.res_scale != exp_o.res_scale)
                report("res_scale", exp_o.res_scale, got.res_scale);
            if (got.harmonic_order != exp_o.harmonic_order)
                report("harmonic_order", exp_o.harmonic_order, got.harmonic_order);
            if (got.iters_per_frame != exp_o.iters_per_frame)
                report("iters_per_frame", exp_o.iters_per_frame, got.iters_per_frame);
            if (got.half_precision != exp_o.half_precision)
                report("half_precision", exp_o.half_precision, got.half_precision);
            if (got.densify != exp_o.densify)
                report("densify", exp_o.densify, got.densify);
            if (got.depth_weight != exp_o.depth_weight)
                report("depth_weight", exp_o.depth_weight, got.depth_weight);
            if (got.back_path != exp_o.back_path)
                report("back_path", exp_o.back_path, got.back_path);
            if (got.tier != exp_o.tier)
                report("tier", exp_o.tier, got.tier);
        endfunction

        function void report(string fld, int unsigned e, int unsigned a);
            $display("%0t: %s expected %0d actual %0d", $time, fld, e, a);
            errors++;
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    aqpg_in_t in_data = '0;
    logic out_valid;
    logic out_stall = 0;
    aqpg_out_t out_data;
    logic cfg_we = 0;
    logic [2:0] cfg_index = '0;
    logic [19:0] cfg_data = '0;

    governor_scoreboard sb = new();
    bit calm = 0;
    int unsigned cycles = 0;

    adaptive_quality_pid_governor_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("adaptive_quality_pid_governor_unit_tb failed");
            $finish;
        end
    end

    // Check results and drive receiver stall bursts.
    int unsigned stall_left = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(out_data);
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 5);
                out_stall <= 1;
            end
            else
                out_stall <= 0;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [19:0] v);
        @(posedge clk);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
        sb.write_reg(idx, v);
        @(posedge clk);
        cfg_we <= 0;
    endtask

    // Hold valid across back-to-back requests; drop it only for an idle gap.
    task automatic send_request(aqpg_in_t r);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1; in_data <= r;
        do @(posedge clk); while (in_stall);
        sb.note_request(r);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic aqpg_in_t random_request();
        aqpg_in_t r;
        r = 72'({$urandom, $urandom, $urandom});
        case ($urandom_range(0, 3))
            0: r.headroom = 16'($urandom_range(32769, 65535));
            1: r.headroom = 16'($urandom_range(19661, 32768));
            2: r.headroom = 16'($urandom_range(9831, 19660));
            default: r.headroom = 16'($urandom_range(0, 9830));
        endcase
        case ($urandom_range(0, 4))
            0: r.free_mem_mb = 16'd0;
            1: r.free_mem_mb = 16'($urandom_range(1, 120));
            2: r.free_mem_mb = 16'($urandom_range(1, 60));
            default: ;
        endcase
        if ($urandom_range(0, 2) == 0) r.quality_db = 16'($urandom_range(0, 5200));
        if ($urandom_range(0, 4) != 0) r.goal_fps = 8'($urandom_range(0, 70));
        if ($urandom_range(0, 4) != 0) r.frame_ms = 16'($urandom_range(2000, 14000));
        return r;
    endfunction

    aqpg_in_t d;
    initial
    begin
        sb.reset_state();
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // Directed: tiers, edges, zero rate, unknown memory, low quality.
        d = '{16'hFFFF, 16'd0, 16'd0, 8'd0, 16'd0};           send_request(d);
        d = '{16'd32768, 16'd1, 16'd1, 8'd255, 16'hFFFF};      send_request(d);
        d = '{16'd32769, 16'd49, 16'd5119, 8'd60, 16'd4267};   send_request(d);
        d = '{16'd19660, 16'd50, 16'd5120, 8'd30, 16'd8533};   send_request(d);
        d = '{16'd19661, 16'd99, 16'd2560, 8'd50, 16'd20000};  send_request(d);
        d = '{16'd9830, 16'd100, 16'hFFFF, 8'd1, 16'd0};       send_request(d);
        d = '{16'd9831, 16'hFFFF, 16'd100, 8'd24, 16'hFFFF};   send_request(d);
        d = '{16'd0, 16'd40, 16'd3000, 8'd0, 16'hFFFF};        send_request(d);
        d = '{16'h5555, 16'hAAAA, 16'h5555, 8'hAA, 16'h5555};  send_request(d);
        d = '{16'hAAAA, 16'h5555, 16'hAAAA, 8'h55, 16'hAAAA};  send_request(d);
        drain();
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                1:
                begin
                    write_reg(CfgBudgetMax, 20'hFFFFF); write_reg(CfgBudgetMin, 20'd0);
                    write_reg(CfgScaleMin, 20'd0); write_reg(CfgScaleMax, 20'hFFFFF);
                    write_reg(CfgModeFlags, 20'd3); write_reg(CfgGainP, 20'hFFFF);
                    write_reg(CfgGainI, 20'hFFFF); write_reg(CfgGainD, 20'hFFFF);
                end
                2:
                begin
                    // crossed bounds
                    write_reg(CfgBudgetMax, 20'd5000); write_reg(CfgBudgetMin, 20'd90000);
                    write_reg(CfgScaleMin, 20'd30000); write_reg(CfgScaleMax, 20'd8000);
                    write_reg(CfgModeFlags, 20'd1); write_reg(CfgGainP, 20'd0);
                    write_reg(CfgGainI, 20'd0); write_reg(CfgGainD, 20'd0);
                end
                3, 4:
                begin
                    write_reg(CfgBudgetMax, 20'($urandom_range(0, 20'hFFFFF)));
                    write_reg(CfgBudgetMin, 20'($urandom_range(0, 200000)));
                    write_reg(CfgScaleMin, 20'($urandom_range(0, 32768)));
                    write_reg(CfgScaleMax, 20'($urandom_range(0, 32768)));
                    write_reg(CfgModeFlags, 20'($urandom_range(0, 3)));
                    write_reg(CfgGainP, 20'($urandom_range(0, 1024)));
                    write_reg(CfgGainI, 20'($urandom_range(0, 64)));
                    write_reg(CfgGainD, 20'($urandom_range(0, 256)));
                end
                5:
                begin
                    write_reg(CfgBudgetMax, 20'd100000); write_reg(CfgBudgetMin, 20'd10000);
                    write_reg(CfgScaleMin, 20'd16384); write_reg(CfgScaleMax, 20'd32768);
                    write_reg(CfgModeFlags, 20'd2); write_reg(CfgGainP, 20'd128);
                    write_reg(CfgGainI, 20'd3); write_reg(CfgGainD, 20'd13);
                    calm = 1;
                end
                default: ;
            endcase
            for (int n = 0; n < 190; n++)
                send_request(random_request());
            drain();
        end
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("adaptive_quality_pid_governor_unit_tb passed");
        else
            $display("adaptive_quality_pid_governor_unit_tb failed");
        $finish;
    end
endmodule
